@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define DDWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that also runs through reset.
`define DDWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hdl/ddws_pkg.sv @@
// ----------------------------------------------------------------------------
// ddws_pkg
// Shared types, register map and reset values of the wheel sync block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddws_pkg;

    localparam int COUNT_WIDTH_DEF = 24;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_BASE_SPEED  = 3'd0;
    localparam logic [2:0] REG_GAIN        = 3'd1;
    localparam logic [2:0] REG_TICKS_CM    = 3'd2;
    localparam logic [2:0] REG_TICKS_DEG   = 3'd3;
    localparam logic [2:0] REG_MARGIN      = 3'd4;
    localparam logic [2:0] REG_INTERVAL    = 3'd5;

    localparam logic [7:0]  RST_BASE_SPEED = 8'd200;
    localparam logic [15:0] RST_GAIN       = 16'd256;
    localparam logic [15:0] RST_TICKS_CM   = 16'd2560;
    localparam logic [15:0] RST_TICKS_DEG  = 16'd512;
    localparam logic [15:0] RST_MARGIN     = 16'd10;
    localparam logic [15:0] RST_INTERVAL   = 16'd20;

    // move kinds
    localparam logic KIND_STRAIGHT = 1'b0;
    localparam logic KIND_TURN     = 1'b1;

    // drive limits
    localparam int DRIVE_MAX = 255;
    localparam int DRIVE_MIN = -255;

    // result stream: drive_left, drive_right, clear_counts, current_step
    localparam int OUT_BITS = 27;
    localparam int OUT_W    = 32;

    typedef struct packed {
        logic [7:0]  base_speed;
        logic [15:0] gain_q8;
        logic [15:0] ticks_per_cm_q8;
        logic [15:0] ticks_per_degree_q8;
        logic [15:0] margin_ticks;
        logic [15:0] interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [7:0]        step;
        logic [31:0]       last_ms;
        logic signed [8:0] held_left;
        logic signed [8:0] held_right;
    } t_state;

    typedef struct packed {
        logic              acted;
        logic              arrived;
        logic signed [8:0] drive_left;
        logic signed [8:0] drive_right;
        logic [7:0]        step;
    } t_law_res;

endpackage

@@ hdl/ddws_cfg.sv @@
// ----------------------------------------------------------------------------
// ddws_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddws_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ddws_pkg::ADDR_W-1:0]  paddr,
    input  logic [ddws_pkg::DATA_W-1:0]  pwdata,
    output logic [ddws_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ddws_pkg::t_cfg               o_cfg
);

    ddws_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_speed          <= ddws_pkg::RST_BASE_SPEED;
            r_cfg.gain_q8             <= ddws_pkg::RST_GAIN;
            r_cfg.ticks_per_cm_q8     <= ddws_pkg::RST_TICKS_CM;
            r_cfg.ticks_per_degree_q8 <= ddws_pkg::RST_TICKS_DEG;
            r_cfg.margin_ticks        <= ddws_pkg::RST_MARGIN;
            r_cfg.interval_ms         <= ddws_pkg::RST_INTERVAL;
        end else if (wr_en) begin
            case (reg_idx)
                ddws_pkg::REG_BASE_SPEED: r_cfg.base_speed          <= pwdata[7:0];
                ddws_pkg::REG_GAIN:       r_cfg.gain_q8             <= pwdata[15:0];
                ddws_pkg::REG_TICKS_CM:   r_cfg.ticks_per_cm_q8     <= pwdata[15:0];
                ddws_pkg::REG_TICKS_DEG:  r_cfg.ticks_per_degree_q8 <= pwdata[15:0];
                ddws_pkg::REG_MARGIN:     r_cfg.margin_ticks        <= pwdata[15:0];
                ddws_pkg::REG_INTERVAL:   r_cfg.interval_ms         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ddws_pkg::REG_BASE_SPEED: prdata = {24'd0, r_cfg.base_speed};
            ddws_pkg::REG_GAIN:       prdata = {16'd0, r_cfg.gain_q8};
            ddws_pkg::REG_TICKS_CM:   prdata = {16'd0, r_cfg.ticks_per_cm_q8};
            ddws_pkg::REG_TICKS_DEG:  prdata = {16'd0, r_cfg.ticks_per_degree_q8};
            ddws_pkg::REG_MARGIN:     prdata = {16'd0, r_cfg.margin_ticks};
            ddws_pkg::REG_INTERVAL:   prdata = {16'd0, r_cfg.interval_ms};
            default:                  prdata = '0;
        endcase
    end

endmodule

@@ hdl/ddws_law.sv @@
// ----------------------------------------------------------------------------
// ddws_law
// Control law: action gate, proportional drives and arrival test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddws_law #(
    parameter int COUNT_WIDTH = ddws_pkg::COUNT_WIDTH_DEF
) (
    input  ddws_pkg::t_cfg                 i_cfg,
    input  ddws_pkg::t_state               i_state,
    input  logic                           i_kind,
    input  logic [7:0]                     i_call,
    input  logic signed [15:0]             i_target,
    input  logic signed [COUNT_WIDTH-1:0]  i_left,
    input  logic signed [COUNT_WIDTH-1:0]  i_right,
    input  logic [31:0]                    i_now,
    output ddws_pkg::t_law_res             o_res
);

    localparam int EW = COUNT_WIDTH + 1;            // tick error
    localparam int CW = COUNT_WIDTH + 18;           // gain times error
    localparam int SW = COUNT_WIDTH + 19;           // Q8.8 drive sum
    localparam int QW = SW - 8;                     // sum after the shift
    localparam int TW = 33;                         // target in Q8.8 ticks
    localparam int AW = ((COUNT_WIDTH + 8 > TW) ? COUNT_WIDTH + 8 : TW) + 1;

    localparam logic signed [QW-1:0] QMAX = QW'(ddws_pkg::DRIVE_MAX);
    localparam logic signed [QW-1:0] QMIN = QW'(ddws_pkg::DRIVE_MIN);

    // Truncate toward zero by 256, then clamp to the drive range.
    function automatic logic signed [8:0] to_drive(input logic signed [SW-1:0] sum);
        logic signed [SW-1:0] adj;
        logic signed [QW-1:0] q;
        adj = sum + (sum[SW-1] ? SW'(255) : SW'(0));
        q   = adj[SW-1:8];
        if (q > QMAX) begin
            to_drive = 9'(ddws_pkg::DRIVE_MAX);
        end else if (q < QMIN) begin
            to_drive = 9'(ddws_pkg::DRIVE_MIN);
        end else begin
            to_drive = q[8:0];
        end
    endfunction

    logic                   turn;
    logic                   tneg;
    logic                   act;
    logic signed [EW-1:0]   err;
    logic signed [16:0]     gain_s;
    logic signed [CW-1:0]   corr;
    logic signed [SW-1:0]   corr_x;
    logic signed [SW-1:0]   base_x;
    logic signed [SW-1:0]   sum_l;
    logic signed [SW-1:0]   sum_r;
    logic signed [16:0]     tpu_s;
    logic signed [TW-1:0]   tq;
    logic signed [AW-1:0]   tq_x;
    logic signed [AW-1:0]   lq_x;
    logic signed [AW-1:0]   rq_x;
    logic signed [AW-1:0]   dev_l;
    logic signed [AW-1:0]   dev_r;
    logic signed [AW-1:0]   mpos;
    logic                   near;
    logic [31:0]            elapsed;

    assign turn    = (i_kind == ddws_pkg::KIND_TURN);
    assign tneg    = i_target[15];
    assign elapsed = i_now - i_state.last_ms;
    assign act     = (i_call == i_state.step) && (elapsed >= {16'd0, i_cfg.interval_ms});

    // drive sums
    assign err    = turn ? (EW'(i_left) + EW'(i_right)) : (EW'(i_left) - EW'(i_right));
    assign gain_s = $signed({1'b0, i_cfg.gain_q8});
    assign corr   = err * gain_s;
    assign corr_x = SW'(corr);
    assign base_x = tneg ? -SW'($signed({1'b0, i_cfg.base_speed, 8'd0}))
                         :  SW'($signed({1'b0, i_cfg.base_speed, 8'd0}));

    always_comb begin
        if (turn) begin
            sum_r = base_x - corr_x;
            sum_l = -base_x - corr_x;
        end else begin
            sum_r = base_x + corr_x;
            sum_l = base_x - corr_x;
        end
    end

    // arrival test in Q8.8 ticks
    assign tpu_s = $signed({1'b0, turn ? i_cfg.ticks_per_degree_q8 : i_cfg.ticks_per_cm_q8});
    assign tq    = i_target * tpu_s;
    assign tq_x  = AW'(tq);
    assign lq_x  = AW'(i_left) <<< 8;
    assign rq_x  = AW'(i_right) <<< 8;
    assign dev_l = turn ? (tq_x + lq_x) : (tq_x - lq_x);
    assign dev_r = tq_x - rq_x;
    assign mpos  = AW'({1'b0, i_cfg.margin_ticks, 8'd0});
    assign near  = (dev_l < mpos) && (dev_l > -mpos) && (dev_r < mpos) && (dev_r > -mpos);

    always_comb begin
        o_res.acted       = act;
        o_res.arrived     = act && near;
        o_res.step        = i_state.step;
        o_res.drive_left  = i_state.held_left;
        o_res.drive_right = i_state.held_right;
        if (act) begin
            if (near) begin
                o_res.drive_left  = '0;
                o_res.drive_right = '0;
                o_res.step        = i_state.step + 8'd1;
            end else begin
                o_res.drive_left  = to_drive(sum_l);
                o_res.drive_right = to_drive(sum_r);
            end
        end
    end

endmodule

@@ hdl/differential_drive_wheel_sync.sv @@
// ----------------------------------------------------------------------------
// differential_drive_wheel_sync
// Path: a request is taken into the input register, passes through the control
//   law and sits in the result register until the master side takes it.
// Throughput: one request per clock unless the result side stalls; the control
//   law is a single pass of one gain multiply and one target multiply between the two registers.
// Reset (synchronous, active low): both stages empty, step, action time and
//   held drives zero, configuration registers at their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_wheel_sync #(
    parameter int COUNT_WIDTH = ddws_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // configuration port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [ddws_pkg::ADDR_W-1:0]               paddr,
    input  logic [ddws_pkg::DATA_W-1:0]               pwdata,
    output logic [ddws_pkg::DATA_W-1:0]               prdata,
    output logic                                      pready,
    // sample stream
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // call_step, target, left_count, right_count, now_ms; zero padded to bytes
    input  logic [((56 + 2*COUNT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // move_kind
    input  logic                                      s_tuser,
    // result stream
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // drive_left, drive_right, clear_counts, current_step; zero padded
    output logic [ddws_pkg::OUT_W-1:0]                m_tdata,
    // acted
    output logic                                      m_tuser,
    // arrived
    output logic                                      m_tlast
);

    // input field offsets inside s_tdata
    localparam int OFS_TARGET = 8;
    localparam int OFS_LEFT   = 24;
    localparam int OFS_RIGHT  = OFS_LEFT + COUNT_WIDTH;
    localparam int OFS_NOW    = OFS_RIGHT + COUNT_WIDTH;

    ddws_pkg::t_cfg      cfg;
    ddws_pkg::t_law_res  law_res;

    // input register
    logic                           r_in_vld;
    logic                           n_in_vld;
    logic                           r_kind;
    logic [7:0]                     r_call;
    logic signed [15:0]             r_target;
    logic signed [COUNT_WIDTH-1:0]  r_left;
    logic signed [COUNT_WIDTH-1:0]  r_right;
    logic [31:0]                    r_now;

    // loop state
    ddws_pkg::t_state    r_state;
    ddws_pkg::t_state    n_state;

    // result register
    logic                r_out_vld;
    logic                n_out_vld;
    ddws_pkg::t_law_res  r_out;

    logic                in_take;
    logic                advance;

    ddws_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ddws_law #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_law (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_kind   (r_kind),
        .i_call   (r_call),
        .i_target (r_target),
        .i_left   (r_left),
        .i_right  (r_right),
        .i_now    (r_now),
        .o_res    (law_res)
    );

    // Advance the held request into the result register whenever that register
    // is empty or drains this cycle; the input stage refills in the same cycle.
    // A stalled result keeps one more request in the input register and only
    // then pushes back on the sender.
    assign advance  = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_in_vld || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_take) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (advance) begin
            n_out_vld = 1'b1;
        end else if (m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    // Update step, action time and held drives only for an acting sample,
    // and only in the cycle it moves on, so the next request sees them.
    always_comb begin
        n_state = r_state;
        if (advance && law_res.acted) begin
            n_state.step       = law_res.step;
            n_state.last_ms    = r_now;
            n_state.held_left  = law_res.drive_left;
            n_state.held_right = law_res.drive_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            r_state   <= n_state;
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind   <= s_tuser;
            r_call   <= s_tdata[7:0];
            r_target <= s_tdata[OFS_TARGET +: 16];
            r_left   <= s_tdata[OFS_LEFT +: COUNT_WIDTH];
            r_right  <= s_tdata[OFS_RIGHT +: COUNT_WIDTH];
            r_now    <= s_tdata[OFS_NOW +: 32];
        end
        if (advance) begin
            r_out <= law_res;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out.acted;
    assign m_tlast  = r_out.arrived;
    // clear_counts rides with arrival
    assign m_tdata  = {(ddws_pkg::OUT_W - ddws_pkg::OUT_BITS)'(0), r_out.step, r_out.arrived,
                       r_out.drive_right, r_out.drive_left};

endmodule

@@ hdl/ddws_checker.sv @@
// ----------------------------------------------------------------------------
// ddws_checker
// Port-level checks on the wheel sync result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ddws_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ddws_pkg::OUT_W-1:0]  m_tdata,
    input logic                        m_tuser,
    input logic                        m_tlast
);

    logic       out_take;
    logic [7:0] out_step;

    assign out_take = m_tvalid && m_tready;
    assign out_step = m_tdata[26:19];

    // both stages come up empty
    `DDWS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!m_tvalid && s_tready), "stages not empty after reset")

    // a stalled result holds
    `DDWS_ASSERT(a_hold_stall, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

    // arrival only on an acting sample, with drives zeroed and clear raised
    `DDWS_ASSERT(a_arrive_form, (m_tvalid && m_tlast) |-> (m_tuser && m_tdata[18] && (m_tdata[17:0] == 18'd0)), "malformed arrival")

    // the step moves by one exactly on arrival between back-to-back results
    `DDWS_ASSERT(a_step_adv, ($past(out_take) && out_take) |-> (out_step == 8'($past(out_step) + {7'd0, m_tlast})), "step jumped")

endmodule

bind differential_drive_wheel_sync ddws_checker u_ddws_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ test/differential_drive_wheel_sync_tb.sv @@
// ----------------------------------------------------------------------------
// differential_drive_wheel_sync_tb
// Drives sample requests and register writes into the wheel sync block,
// predicts every result from its own copy of the control law and state, and
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Prediction and checking of the result stream.
class wheel_sync_board;
    localparam int CW = ddws_pkg::COUNT_WIDTH_DEF;

    ddws_pkg::t_cfg     cfg;
    ddws_pkg::t_state   st;
    ddws_pkg::t_law_res pending_results[$];
    int                 mismatches;
    int                 results_seen;

    function new();
        cfg.base_speed          = ddws_pkg::RST_BASE_SPEED;
        cfg.gain_q8             = ddws_pkg::RST_GAIN;
        cfg.ticks_per_cm_q8     = ddws_pkg::RST_TICKS_CM;
        cfg.ticks_per_degree_q8 = ddws_pkg::RST_TICKS_DEG;
        cfg.margin_ticks        = ddws_pkg::RST_MARGIN;
        cfg.interval_ms         = ddws_pkg::RST_INTERVAL;
        st           = '0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            ddws_pkg::REG_BASE_SPEED: cfg.base_speed          = value[7:0];
            ddws_pkg::REG_GAIN:       cfg.gain_q8             = value[15:0];
            ddws_pkg::REG_TICKS_CM:   cfg.ticks_per_cm_q8     = value[15:0];
            ddws_pkg::REG_TICKS_DEG:  cfg.ticks_per_degree_q8 = value[15:0];
            ddws_pkg::REG_MARGIN:     cfg.margin_ticks        = value[15:0];
            ddws_pkg::REG_INTERVAL:   cfg.interval_ms         = value[15:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
        case (idx)
            ddws_pkg::REG_BASE_SPEED: return 32'(cfg.base_speed);
            ddws_pkg::REG_GAIN:       return 32'(cfg.gain_q8);
            ddws_pkg::REG_TICKS_CM:   return 32'(cfg.ticks_per_cm_q8);
            ddws_pkg::REG_TICKS_DEG:  return 32'(cfg.ticks_per_degree_q8);
            ddws_pkg::REG_MARGIN:     return 32'(cfg.margin_ticks);
            ddws_pkg::REG_INTERVAL:   return 32'(cfg.interval_ms);
            default:                  return '0;
        endcase
    endfunction

    // Q8.8 sum -> whole drive, truncated toward zero, then clamped.
    static function logic signed [8:0] drive_of(longint q8sum);
        longint v;
        v = q8sum / 256;
        if (v > ddws_pkg::DRIVE_MAX) v = ddws_pkg::DRIVE_MAX;
        if (v < ddws_pkg::DRIVE_MIN) v = ddws_pkg::DRIVE_MIN;
        return v[8:0];
    endfunction

    static function longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Apply one accepted sample to the predicted state and queue its result.
    function void note_sample(logic kind, logic [7:0] call, logic signed [15:0] tgt,
                              logic signed [CW-1:0] left, logic signed [CW-1:0] right,
                              logic [31:0] now);
        ddws_pkg::t_law_res res;
        logic [31:0]        elapsed;
        longint             base, signed_base, g, margin, lq, rq, t, corr;
        bit                 near;
        elapsed     = now - st.last_ms;
        res.acted   = 1'b0;
        res.arrived = 1'b0;
        if (call == st.step && elapsed >= 32'(cfg.interval_ms)) begin
            base   = longint'(cfg.base_speed) * 256;
            g      = longint'(cfg.gain_q8);
            margin = longint'(cfg.margin_ticks) * 256;
            lq     = longint'(left) * 256;
            rq     = longint'(right) * 256;
            if (kind == ddws_pkg::KIND_STRAIGHT) begin
                // zero target counts as forward
                signed_base   = (tgt < 0) ? -base : base;
                corr          = g * (longint'(left) - longint'(right));
                st.held_right = drive_of(signed_base + corr);
                st.held_left  = drive_of(signed_base - corr);
                t    = longint'(tgt) * longint'(cfg.ticks_per_cm_q8);
                near = mag(t - lq) < margin && mag(t - rq) < margin;
            end else begin
                corr = g * (longint'(left) + longint'(right));
                if (tgt < 0) begin
                    st.held_right = drive_of(-base - corr);
                    st.held_left  = drive_of(base - corr);
                end else begin
                    st.held_right = drive_of(base - corr);
                    st.held_left  = drive_of(-base - corr);
                end
                t    = longint'(tgt) * longint'(cfg.ticks_per_degree_q8);
                near = mag(t + lq) < margin && mag(t - rq) < margin;
            end
            if (near) begin
                st.held_left  = '0;
                st.held_right = '0;
                st.step       = st.step + 8'd1;
            end
            st.last_ms  = now;
            res.acted   = 1'b1;
            res.arrived = near;
        end
        res.drive_left  = st.held_left;
        res.drive_right = st.held_right;
        res.step        = st.step;
        pending_results.push_back(res);
    endfunction

    task report(string what);
        if (mismatches < 200)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // m_tdata: drive_left [8:0], drive_right [17:9], clear_counts [18], step [26:19]
    task check_result(logic [ddws_pkg::OUT_W-1:0] data, logic acted, logic arrived);
        ddws_pkg::t_law_res want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report($sformatf("result %0d arrived with no request waiting", results_seen));
            return;
        end
        want = pending_results.pop_front();
        if (acted !== want.acted)
            report($sformatf("result %0d acted %b, want %b", results_seen, acted, want.acted));
        if (data[8:0] !== want.drive_left)
            report($sformatf("result %0d drive_left %0d, want %0d", results_seen,
                             $signed(data[8:0]), want.drive_left));
        if (data[17:9] !== want.drive_right)
            report($sformatf("result %0d drive_right %0d, want %0d", results_seen,
                             $signed(data[17:9]), want.drive_right));
        if (data[18] !== want.arrived)
            report($sformatf("result %0d clear_counts %b, want %b", results_seen,
                             data[18], want.arrived));
        if (arrived !== want.arrived)
            report($sformatf("result %0d arrived %b, want %b", results_seen,
                             arrived, want.arrived));
        if (data[26:19] !== want.step)
            report($sformatf("result %0d step %0d, want %0d", results_seen,
                             data[26:19], want.step));
    endtask
endclass

module differential_drive_wheel_sync_tb;

    localparam int CW   = ddws_pkg::COUNT_WIDTH_DEF;
    localparam int SD_W = ((56 + 2*CW + 7) / 8) * 8;

    // register slots past the end of the map; writes there must be dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel, penable, pwrite;
    logic [ddws_pkg::ADDR_W-1:0]  paddr;
    logic [ddws_pkg::DATA_W-1:0]  pwdata;
    logic [ddws_pkg::DATA_W-1:0]  prdata;
    logic                         pready;
    logic                         s_tvalid, s_tready;
    logic [SD_W-1:0]              s_tdata;    // call_step, target, left, right, now_ms (low bit up)
    logic                         s_tuser;    // move_kind
    logic                         m_tvalid, m_tready;
    logic [ddws_pkg::OUT_W-1:0]   m_tdata;    // drive_left, drive_right, clear_counts, current_step
    logic                         m_tuser;    // acted
    logic                         m_tlast;    // arrived

    wheel_sync_board sb = new();

    logic [31:0] now_ms;
    int          items_sent;
    bit          sender_calm;

    differential_drive_wheel_sync #(
        .COUNT_WIDTH (CW)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (sender_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] pick_target();
        case ($urandom_range(0, 15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3:       return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    function automatic longint jitter(int a);
        return longint'($urandom_range(0, 2 * a)) - a;
    endfunction

    // Move time on by about one interval; now and then too early to act.
    function automatic void advance_time();
        logic [31:0] dt;
        if ($urandom_range(0, 9) == 0)
            dt = $urandom_range(0, sb.cfg.interval_ms);
        else
            dt = 32'(sb.cfg.interval_ms) + $urandom_range(0, 3);
        now_ms = now_ms + dt;
    endfunction

    // Offer one request, hold it until taken, then note it and idle a while.
    task automatic send_sample(input logic kind, input logic [7:0] call,
                               input logic signed [15:0] tgt,
                               input logic signed [CW-1:0] left,
                               input logic signed [CW-1:0] right,
                               input logic [31:0] now);
        int gap;
        s_tuser  <= kind;
        s_tdata  <= SD_W'({now, right, left, tgt, call});
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        sb.note_sample(kind, call, tgt, left, right, now);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One step of a trajectory: counts walk toward the target ticks and the
    // last sample lands inside the margin, so the step usually advances.
    task automatic run_move(input int n);
        logic              kind;
        logic signed [15:0] tgt;
        logic [7:0]        call;
        longint            tpu, goal, part, l, r;
        int                spread, i;
        kind = ($urandom_range(0, 1) != 0) ? ddws_pkg::KIND_TURN : ddws_pkg::KIND_STRAIGHT;
        tgt  = pick_target();
        if (kind == ddws_pkg::KIND_TURN)
            tpu = longint'(sb.cfg.ticks_per_degree_q8);
        else
            tpu = longint'(sb.cfg.ticks_per_cm_q8);
        goal = longint'(tgt) * tpu / 256;
        for (i = 1; i <= n; i++) begin
            part   = goal * i / n;
            spread = (i == n) ? int'(sb.cfg.margin_ticks) / 2 : int'(sb.cfg.margin_ticks) + 40;
            l = ((kind == ddws_pkg::KIND_TURN) ? -part : part) + jitter(spread);
            r = part + jitter(spread);
            // a broken sequence now and then: sample tagged with a stale or future step
            call = sb.st.step;
            if ($urandom_range(0, 9) == 0)
                call = call + (($urandom_range(0, 1) != 0) ? 8'd1 : 8'hFF);
            advance_time();
            send_sample(kind, call, tgt, l[CW-1:0], r[CW-1:0], now_ms);
        end
    endtask

    task automatic random_phase(input int items, input int max_len, input int noise_pct);
        int stop_at;
        stop_at = items_sent + items;
        while (items_sent < stop_at) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < noise_pct)
                send_sample(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            16'($urandom), CW'($urandom), CW'($urandom), $urandom);
            else
                run_move($urandom_range(1, max_len));
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    // Setup then access; in-range registers are read back right after.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ddws_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        if (idx <= ddws_pkg::REG_INTERVAL) begin
            pwrite  <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== sb.reg_value(idx))
                sb.report($sformatf("register %0d reads %h, want %h",
                                    idx, prdata, sb.reg_value(idx)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] base, gain, tcm, tdeg, margin, interval);
        reg_write(ddws_pkg::REG_BASE_SPEED, base);
        reg_write(ddws_pkg::REG_GAIN, gain);
        reg_write(ddws_pkg::REG_TICKS_CM, tcm);
        reg_write(ddws_pkg::REG_TICKS_DEG, tdeg);
        reg_write(ddws_pkg::REG_MARGIN, margin);
        reg_write(ddws_pkg::REG_INTERVAL, interval);
    endtask

    // Drop valid, wait out every outstanding result, then the pipe latency.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        now_ms      = 32'd0;
        items_sent  = 0;
        sender_calm = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings.
        // zero target, zero counts: arrives at once
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd0, 16'sd0, '0, '0, 32'd20);
        // stale step number: ignored
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd0, 16'sd0, '0, '0, 32'd60);
        // right step but interval not yet elapsed
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd1, 16'sd0, '0, '0, 32'd30);
        // extreme targets and counts: both drives saturate; then a small turn that arrives
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd1, 16'sh7FFF, CNT_MAX, CNT_MIN, 32'd100);
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd1, 16'sh8000, CNT_MIN, CNT_MAX, 32'd200);
        send_sample(ddws_pkg::KIND_TURN, 8'd1, 16'sh7FFF, CNT_MAX, CNT_MAX, 32'd300);
        send_sample(ddws_pkg::KIND_TURN, 8'd1, 16'sh8000, CNT_MIN, CNT_MIN, 32'd400);
        send_sample(ddws_pkg::KIND_TURN, 8'd1, -16'sd1, CW'(5), CW'(-7), 32'd500);
        // turn of 90 degrees reached exactly, but tagged with a stale step: ignored
        send_sample(ddws_pkg::KIND_TURN, 8'd1, 16'sd90, CW'(-180), CW'(180), 32'd600);
        // right wheel exactly one margin off: no arrival
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd2, 16'sd10, CW'(109), CW'(110), 32'd700);
        // interval exactly elapsed, both wheels inside the margin
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd2, 16'sd10, CW'(91), CW'(109), 32'd720);
        // time wrap: acts before the wrap, too early after it, then acts again
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd3, -16'sd5, CW'(-40), CW'(-60),
                    32'hFFFF_FFF0);
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd3, 16'sd1, CW'(3), CW'(1), 32'h0000_0003);
        send_sample(ddws_pkg::KIND_STRAIGHT, 8'd3, 16'sd1, CW'(3), CW'(1), 32'h0000_0004);
        now_ms = 32'h0000_0004;

        random_phase(100, 6, 15);

        // all registers at zero: no base, no gain, zero margin never arrives
        wait_drained();
        configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        random_phase(50, 4, 10);

        // all registers at their top value
        wait_drained();
        configure(32'd255, 32'd65535, 32'd65535, 32'd65535, 32'd65535, 32'd65535);
        now_ms = 32'hFFFF_0000;
        random_phase(60, 4, 10);

        // wide margin and no interval: nearly every sample arrives, the step wraps
        wait_drained();
        configure($urandom, $urandom, 32'd256, 32'd256, 32'd65535, 32'd0);
        reg_write(REG_SPARE_LO, $urandom);
        reg_write(REG_SPARE_HI, $urandom);
        random_phase(330, 2, 3);

        // random settings, upper bus bits random too
        repeat (2) begin
            wait_drained();
            configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 100));
            now_ms = $urandom;
            random_phase(30, 5, 15);
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check every accepted result, stall at random, and once hold
    // off long enough for the block to fill and push back on its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold, calm, r;
        bit long_hold_done;
        hold           = 0;
        calm           = 0;
        long_hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            if (!long_hold_done && sb.results_seen >= 150) begin
                long_hold_done = 1'b1;
                hold           = 300;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (calm > 0) begin
                m_tready <= 1'b1;
                calm--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(0, 2);
                end else if (r < 14) begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end else if (r < 16) begin
                    m_tready <= 1'b1;
                    calm = $urandom_range(40, 120);
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Hard stop far beyond the slowest correct run.
    initial begin : watchdog
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
